@@ design/vhs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhs_pkg
// shared types, codes and constants of the voxel history statistics block
// ----------------------------------------------------------------------------
package vhs_pkg;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned IDX_W  = 12;
  localparam int unsigned AMT_W  = 24;
  localparam int unsigned EVT_W  = 32;
  localparam int unsigned SUM_W  = 48;
  localparam int unsigned SQ_W   = 64;
  localparam int unsigned PEND_W = 32;
  localparam int unsigned UNC_W  = 24;
  localparam int unsigned CNT_W  = 6;

  localparam logic [UNC_W-1:0] UNC_ONE = 24'h010000;
  localparam logic [UNC_W-1:0] UNC_MAX = 24'hFFFFFF;

  // step counts minus one for the iterative units
  localparam logic [CNT_W-1:0] CNT_MUL_S = 6'(SUM_W - 1);
  localparam logic [CNT_W-1:0] CNT_MUL_N = 6'(EVT_W - 1);
  localparam logic [CNT_W-1:0] CNT_DIV   = 6'(SUM_W - 1);
  localparam logic [CNT_W-1:0] CNT_SQRT  = 6'(UNC_W - 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_RESET      = 3'd0,
    CMD_SET        = 3'd1,
    CMD_ADD        = 3'd2,
    CMD_ADD_TEMP   = 3'd3,
    CMD_ADD_UPDATE = 3'd4,
    CMD_READ       = 3'd5,
    CMD_REPORT     = 3'd6
  } vhs_cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] index;
    logic [AMT_W-1:0] amount;
    logic [EVT_W-1:0] event_count;
  } vhs_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] value_out;
    logic [SQ_W-1:0]  squared_out;
    logic [UNC_W-1:0] uncertainty;
    logic             fallback;
    logic             saturated;
  } vhs_result_t;

  typedef struct packed {
    logic [SUM_W-1:0]  sum_v;
    logic [SQ_W-1:0]   square_v;
    logic [PEND_W-1:0] pending_v;
  } vhs_entry_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_SQR,
    OP_EXEC,
    OP_EMIT_FB,
    OP_MUL1_LD,
    OP_MUL_STEP,
    OP_MUL2_LD,
    OP_EMIT_ZERO,
    OP_MUL3_LD,
    OP_EMIT_SAT,
    OP_DIV_LD,
    OP_DIV_STEP,
    OP_SQRT_STEP,
    OP_EMIT_UNC
  } vhs_op_e;

  typedef struct packed {
    vhs_op_e op;
  } vhs_ctl_t;

  typedef struct packed {
    logic in_ok;
    logic need_sqr;
    logic rep_track;
    logic zero_case;
    logic a_gt;
    logic div_sat;
    logic clr_done;
  } vhs_sts_t;

endpackage

@@ design/vhs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhs_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module vhs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/vhs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhs_ctrl
// sequencer: clearing pass, command execution and the report arithmetic steps
// ----------------------------------------------------------------------------
module vhs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  vhs_pkg::vhs_sts_t sts_i,
  output vhs_pkg::vhs_ctl_t ctl_o
);
  import vhs_pkg::*;

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_SQR   = 13'b0000000000100,
    S_EXEC  = 13'b0000000001000,
    S_UCHK  = 13'b0000000010000,
    S_MUL1  = 13'b0000000100000,
    S_LD2   = 13'b0000001000000,
    S_MUL2  = 13'b0000010000000,
    S_RCHK  = 13'b0000100000000,
    S_MUL3  = 13'b0001000000000,
    S_DCHK  = 13'b0010000000000,
    S_DIV   = 13'b0100000000000,
    S_SQRT  = 13'b1000000000000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             fin_q, fin_d;
  logic             cnt_zero;

  assign cnt_zero = (cnt_q == '0);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    fin_d     = 1'b0;
    ctl_o.op  = OP_NONE;
    if (fin_q) begin
      // last sqrt step done, hand out the result
      ctl_o.op = OP_EMIT_UNC;
    end
    unique case (state_q)
      S_CLEAR: begin
        ctl_o.op = OP_CLEAR;
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start && !fin_q) begin
          ctl_o.op = OP_ACCEPT;
          if (sts_i.in_ok) begin
            state_d = sts_i.need_sqr ? S_SQR : S_EXEC;
          end
        end
      end
      S_SQR: begin
        ctl_o.op = OP_SQR;
        state_d  = S_EXEC;
      end
      S_EXEC: begin
        ctl_o.op = OP_EXEC;
        state_d  = sts_i.rep_track ? S_UCHK : S_IDLE;
      end
      S_UCHK: begin
        if (sts_i.zero_case) begin
          ctl_o.op = OP_EMIT_FB;
          state_d  = S_IDLE;
        end else begin
          ctl_o.op = OP_MUL1_LD;
          cnt_d    = CNT_MUL_S;
          state_d  = S_MUL1;
        end
      end
      S_MUL1: begin
        ctl_o.op = OP_MUL_STEP;
        cnt_d    = cnt_q - 6'd1;
        if (cnt_zero) begin
          state_d = S_LD2;
        end
      end
      S_LD2: begin
        ctl_o.op = OP_MUL2_LD;
        cnt_d    = CNT_MUL_N;
        state_d  = S_MUL2;
      end
      S_MUL2: begin
        ctl_o.op = OP_MUL_STEP;
        cnt_d    = cnt_q - 6'd1;
        if (cnt_zero) begin
          state_d = S_RCHK;
        end
      end
      S_RCHK: begin
        if (!sts_i.a_gt) begin
          ctl_o.op = OP_EMIT_ZERO;
          state_d  = S_IDLE;
        end else begin
          ctl_o.op = OP_MUL3_LD;
          cnt_d    = CNT_MUL_N;
          state_d  = S_MUL3;
        end
      end
      S_MUL3: begin
        ctl_o.op = OP_MUL_STEP;
        cnt_d    = cnt_q - 6'd1;
        if (cnt_zero) begin
          state_d = S_DCHK;
        end
      end
      S_DCHK: begin
        if (sts_i.div_sat) begin
          ctl_o.op = OP_EMIT_SAT;
          state_d  = S_IDLE;
        end else begin
          ctl_o.op = OP_DIV_LD;
          cnt_d    = CNT_DIV;
          state_d  = S_DIV;
        end
      end
      S_DIV: begin
        ctl_o.op = OP_DIV_STEP;
        cnt_d    = cnt_q - 6'd1;
        if (cnt_zero) begin
          cnt_d   = CNT_SQRT;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        ctl_o.op = OP_SQRT_STEP;
        cnt_d    = cnt_q - 6'd1;
        if (cnt_zero) begin
          fin_d   = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // busy also covers the cycle in which the report result is emitted
  assign busy = (state_q != S_IDLE) || fin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      fin_q   <= fin_d;
    end
  end

  a_bad_item_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start && !fin_q && !sts_i.in_ok) |=> state_q == S_IDLE)
    else $error("unused command or index left idle");

  a_div_to_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_zero) |=> (state_q == S_SQRT && cnt_q == CNT_SQRT))
    else $error("sqrt not started after divide");

  a_fin_after_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> ($past(state_q) == S_SQRT && state_q == S_IDLE))
    else $error("report emit out of sequence");

endmodule

@@ design/vhs_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhs_dp
// datapath: voxel store, update arithmetic and report divide / square root
// ----------------------------------------------------------------------------
module vhs_dp #(
  parameter int unsigned VOXELS       = 4096,
  parameter int unsigned DEPOSIT_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vhs_pkg::vhs_ctl_t    ctl_i,
  output vhs_pkg::vhs_sts_t    sts_o,
  input  vhs_pkg::vhs_item_t   item_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  output logic                 result_strobe_o,
  output vhs_pkg::vhs_result_t result_o
);
  import vhs_pkg::*;

  localparam int unsigned AW = (VOXELS > 1) ? $clog2(VOXELS) : 1;
  localparam logic [20:0] VOX_LIM = 21'(VOXELS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(VOXELS - 1);
  localparam logic [AMT_W-1:0] AMT_MASK = (DEPOSIT_BITS >= AMT_W) ? {AMT_W{1'b1}} :
                                          AMT_W'((33'd1 << DEPOSIT_BITS) - 33'd1);

  // configuration and control
  logic              en_q;
  logic [AW-1:0]     clr_addr_q;
  logic              res_valid_q;

  // latched item
  logic [CMD_W-1:0]  cmd_q;
  logic [AW-1:0]     addr_q;
  logic [AMT_W-1:0]  amt_q;
  logic [EVT_W-1:0]  n_q;
  logic [SQ_W-1:0]   sqr_q;

  // report operands
  logic [SUM_W-1:0]  s_q;
  logic [SQ_W-1:0]   sqs_q;
  logic              satf_q;

  // shift-add multiplier, divider and root
  logic [127:0]      acc_q;
  logic [127:0]      mcand_q;
  logic [47:0]       mplier_q;
  logic [95:0]       s2_q;
  logic [95:0]       r_q;
  logic [127:0]      rem_q;
  logic [47:0]       lsh_q;
  logic [47:0]       quo_q;
  logic [25:0]       srem_q;
  logic [UNC_W-1:0]  root_q;

  vhs_result_t       res_q;

  // ram
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [AW-1:0]              ram_raddr;
  logic [$bits(vhs_entry_t)-1:0] ram_wdata;
  logic [$bits(vhs_entry_t)-1:0] ram_rdata;
  vhs_entry_t                 ent;
  vhs_entry_t                 new_ent;
  logic                       wr;
  logic                       sat;

  logic [AMT_W-1:0]  amt_m;
  logic [SUM_W-1:0]  sum_b;
  logic [SUM_W:0]    sum_add;
  logic [SUM_W-1:0]  sum_sat;
  logic [SQ_W:0]     sq_add;
  logic [SQ_W-1:0]   sq_sat;
  logic [PEND_W:0]   pend_add;
  logic              rep_track;

  logic [128:0]      div_shift;
  logic              div_ge;
  logic [27:0]       sq_trem;
  logic [27:0]       sq_trial;
  logic              sq_ge;

  assign amt_m = item_i.amount & AMT_MASK;
  assign ent   = vhs_entry_t'(ram_rdata);

  assign rep_track = (cmd_q == CMD_REPORT) && en_q;

  // status for the sequencer
  assign sts_o.in_ok     = (item_i.command <= CMD_REPORT) &&
                           (21'(item_i.index) < VOX_LIM);
  assign sts_o.need_sqr  = ((item_i.command == CMD_ADD_UPDATE) ||
                            (item_i.command == CMD_REPORT)) && en_q;
  assign sts_o.rep_track = rep_track;
  assign sts_o.zero_case = (s_q == '0) || (sqs_q == '0) || (n_q <= 32'd1);
  assign sts_o.a_gt      = acc_q[95:0] > s2_q;
  assign sts_o.div_sat   = 128'(r_q[95:16]) >= acc_q;
  assign sts_o.clr_done  = (clr_addr_q == LAST_ADDR);

  // store update of one entry
  assign sum_b    = (cmd_q == CMD_ADD) ? SUM_W'(amt_q) : SUM_W'(ent.pending_v);
  assign sum_add  = {1'b0, ent.sum_v} + {1'b0, sum_b};
  assign sum_sat  = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
  assign sq_add   = {1'b0, ent.square_v} + {1'b0, sqr_q};
  assign sq_sat   = sq_add[SQ_W] ? {SQ_W{1'b1}} : sq_add[SQ_W-1:0];
  assign pend_add = {1'b0, ent.pending_v} + (PEND_W + 1)'(amt_q);

  always_comb begin
    new_ent = ent;
    wr      = 1'b0;
    sat     = 1'b0;
    unique case (cmd_q)
      CMD_RESET: begin
        new_ent.sum_v     = SUM_W'(amt_q);
        new_ent.square_v  = en_q ? sqr_q : ent.square_v;
        new_ent.pending_v = '0;
        wr                = 1'b1;
      end
      CMD_SET: begin
        new_ent.sum_v = SUM_W'(amt_q);
        wr            = 1'b1;
      end
      CMD_ADD: begin
        new_ent.sum_v = sum_sat;
        sat           = sum_add[SUM_W];
        wr            = 1'b1;
      end
      CMD_ADD_TEMP: begin
        new_ent.pending_v = pend_add[PEND_W] ? {PEND_W{1'b1}} : pend_add[PEND_W-1:0];
        sat               = pend_add[PEND_W];
        wr                = 1'b1;
      end
      CMD_ADD_UPDATE: begin
        new_ent.sum_v     = sum_sat;
        new_ent.square_v  = en_q ? sq_sat : ent.square_v;
        new_ent.pending_v = PEND_W'(amt_q);
        sat               = sum_add[SUM_W] || (en_q && sq_add[SQ_W]);
        wr                = 1'b1;
      end
      CMD_REPORT: begin
        if (en_q) begin
          new_ent.sum_v     = sum_sat;
          new_ent.square_v  = sq_sat;
          new_ent.pending_v = '0;
          sat               = sum_add[SUM_W] || sq_add[SQ_W];
          wr                = 1'b1;
        end
      end
      default: begin
        wr = 1'b0;
      end
    endcase
  end

  assign ram_we    = (ctl_i.op == OP_CLEAR) || ((ctl_i.op == OP_EXEC) && wr);
  assign ram_waddr = (ctl_i.op == OP_CLEAR) ? clr_addr_q : addr_q;
  assign ram_wdata = (ctl_i.op == OP_CLEAR) ? '0 : new_ent;
  assign ram_raddr = (ctl_i.op == OP_ACCEPT) ? AW'(item_i.index) : addr_q;

  vhs_ram #(
    .WIDTH ($bits(vhs_entry_t)),
    .DEPTH (VOXELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // divider and root steps
  assign div_shift = {rem_q, lsh_q[47]};
  assign div_ge    = div_shift >= {1'b0, acc_q};
  assign sq_trem   = {srem_q, quo_q[47:46]};
  assign sq_trial  = 28'({root_q, 2'b01});
  assign sq_ge     = sq_trem >= sq_trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q        <= 1'b0;
      clr_addr_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        en_q <= cfg_wdata_i;
      end
      if (ctl_i.op == OP_CLEAR && !sts_o.clr_done) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      res_valid_q <= ((ctl_i.op == OP_EXEC) && !rep_track) ||
                     (ctl_i.op == OP_EMIT_FB) || (ctl_i.op == OP_EMIT_ZERO) ||
                     (ctl_i.op == OP_EMIT_SAT) || (ctl_i.op == OP_EMIT_UNC);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctl_i.op)
      OP_ACCEPT: begin
        cmd_q  <= item_i.command;
        addr_q <= AW'(item_i.index);
        amt_q  <= amt_m;
        n_q    <= item_i.event_count;
        sqr_q  <= SQ_W'({24'b0, amt_m} * {24'b0, amt_m});
      end
      OP_SQR: begin
        sqr_q <= {32'b0, ent.pending_v} * {32'b0, ent.pending_v};
      end
      OP_EXEC: begin
        s_q    <= new_ent.sum_v;
        sqs_q  <= new_ent.square_v;
        satf_q <= sat;
        res_q  <= '{value_out: new_ent.sum_v, squared_out: new_ent.square_v,
                    uncertainty: '0, fallback: 1'b0, saturated: sat};
      end
      OP_EMIT_FB: begin
        res_q <= '{value_out: s_q, squared_out: sqs_q, uncertainty: UNC_ONE,
                   fallback: 1'b1, saturated: satf_q};
      end
      OP_EMIT_ZERO: begin
        res_q <= '{value_out: s_q, squared_out: sqs_q, uncertainty: '0,
                   fallback: 1'b0, saturated: satf_q};
      end
      OP_EMIT_SAT: begin
        res_q <= '{value_out: s_q, squared_out: sqs_q, uncertainty: UNC_MAX,
                   fallback: 1'b0, saturated: 1'b1};
      end
      OP_EMIT_UNC: begin
        res_q <= '{value_out: s_q, squared_out: sqs_q, uncertainty: root_q,
                   fallback: 1'b0, saturated: satf_q};
      end
      OP_MUL1_LD: begin
        acc_q    <= '0;
        mcand_q  <= 128'(s_q);
        mplier_q <= s_q;
      end
      OP_MUL_STEP: begin
        if (mplier_q[0]) begin
          acc_q <= acc_q + mcand_q;
        end
        mcand_q  <= {mcand_q[126:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[47:1]};
      end
      OP_MUL2_LD: begin
        s2_q     <= acc_q[95:0];
        acc_q    <= '0;
        mcand_q  <= 128'(sqs_q);
        mplier_q <= 48'(n_q);
      end
      OP_MUL3_LD: begin
        r_q      <= acc_q[95:0] - s2_q;
        acc_q    <= '0;
        mcand_q  <= 128'(s2_q);
        mplier_q <= 48'(n_q - 32'd1);
      end
      OP_DIV_LD: begin
        // dividend is r * 2^32, upper part first
        rem_q  <= 128'(r_q[95:16]);
        lsh_q  <= {r_q[15:0], 32'b0};
        quo_q  <= '0;
        srem_q <= '0;
        root_q <= '0;
      end
      OP_DIV_STEP: begin
        rem_q <= div_ge ? 128'(div_shift - {1'b0, acc_q}) : div_shift[127:0];
        quo_q <= {quo_q[46:0], div_ge};
        lsh_q <= {lsh_q[46:0], 1'b0};
      end
      OP_SQRT_STEP: begin
        srem_q <= sq_ge ? 26'(sq_trem - sq_trial) : sq_trem[25:0];
        root_q <= {root_q[UNC_W-2:0], sq_ge};
        quo_q  <= {quo_q[45:0], 2'b00};
      end
      default: begin
      end
    endcase
  end

  assign result_strobe_o = res_valid_q;
  assign result_o        = res_q;

  a_strobe_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> ($past(ctl_i.op) == OP_EXEC || $past(ctl_i.op) == OP_EMIT_FB ||
                     $past(ctl_i.op) == OP_EMIT_ZERO || $past(ctl_i.op) == OP_EMIT_SAT ||
                     $past(ctl_i.op) == OP_EMIT_UNC))
    else $error("result strobe without an emitting step");

  a_div_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.op == OP_DIV_STEP) |-> (rem_q < acc_q))
    else $error("divider remainder not below divisor");

  a_read_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ctl_i.op == OP_EXEC) |-> (cmd_q != CMD_READ))
    else $error("read command wrote the store");

endmodule

@@ design/voxel_history_statistics.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_history_statistics
// per-voxel history-by-history sum, sum of squares and relative uncertainty
// ----------------------------------------------------------------------------
//
// channel   | ports                                    | direction
// ----------+------------------------------------------+-----------
// command   | start, busy, item_i                      | in
// config    | cfg_we_i, cfg_wdata_i                    | in
// result    | result_strobe_o, result_o                | out
//
// a transaction is accepted on the edge with start high and busy low
// plain commands: accept, square step when a deposit is squared, execute
// a tracked report runs a shift-add multiplier three times (48, 32, 32
// steps), a 48 step divider and a 24 step root, cut short on the fallback,
// non-positive radicand and saturated uncertainty shortcuts
// after reset a clearing pass writes every store entry once with busy high;
// the result strobe lasts one cycle and cannot be stalled
// ----------------------------------------------------------------------------
module voxel_history_statistics #(
  parameter int unsigned VOXELS       = 4096,
  parameter int unsigned DEPOSIT_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command transaction
  input  logic                 start,
  output logic                 busy,
  input  vhs_pkg::vhs_item_t   item_i,
  // squared tracking enable register
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  // result transaction
  output logic                 result_strobe_o,
  output vhs_pkg::vhs_result_t result_o
);
  import vhs_pkg::*;

  // command / status between sequencer and datapath
  vhs_ctl_t ctl;
  vhs_sts_t sts;

  // sequencer: owns busy and the step counters
  vhs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  // datapath: store ram, update adders, multiplier, divider and root
  vhs_dp #(
    .VOXELS       (VOXELS),
    .DEPOSIT_BITS (DEPOSIT_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .item_i          (item_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for voxel_history_statistics: a predictor with its own
// per-voxel sum, square and pending stores works out every result, which is
// compared field by field with the strobed output; directed corner cases,
// then random command sequences over a few hot voxels, with tracking toggled
// ----------------------------------------------------------------------------
module tb_top;
  import vhs_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int unsigned      VOXELS     = 4096;
  localparam int unsigned      LIMIT      = 3000000;
  localparam int unsigned      SETTLE     = 300;  // longer than a tracked report

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  vhs_item_t   item_i = '0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        result_strobe_o;
  vhs_result_t result_o;

  voxel_history_statistics #(
    .VOXELS      (VOXELS),
    .DEPOSIT_BITS(24)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_strobe_o(result_strobe_o),
    .result_o       (result_o)
  );

  always #10 clk_i = ~clk_i;

  // predictor state, mirrors the block's stores
  logic [SUM_W-1:0]  sum_mem  [VOXELS];
  logic [SQ_W-1:0]   sq_mem   [VOXELS];
  logic [PEND_W-1:0] pend_mem [VOXELS];
  bit                track_en;

  vhs_result_t expected_q[$];
  int unsigned errors, results_seen, items_sent, reports_sent, cycles;

  // ---------------------------------------------------------------------------
  // uncertainty in Q8.16: floor(65536*sqrt(R/(N-1))/sum), done exactly on
  // 192 bit integers by a bitwise search on u^2 * sum^2 * (N-1) <= R * 2^32
  // ---------------------------------------------------------------------------
  function automatic void rel_uncertainty(input logic [SUM_W-1:0] s,
                                          input logic [SQ_W-1:0] sq,
                                          input logic [EVT_W-1:0] n,
                                          output logic [UNC_W-1:0] u,
                                          output bit fb, inout bit sat);
    logic [191:0] s2, a, r, l, d, c;
    u  = '0;
    fb = 1'b0;
    if (s == 0 || sq == 0 || n <= 1) begin
      fb = 1'b1;
      u  = UNC_ONE;
      return;
    end
    s2 = 192'(s) * 192'(s);
    a  = 192'(sq) * 192'(n);
    // negative or zero radicand clamps to zero
    if (a <= s2) return;
    r = a - s2;
    l = r << 32;
    d = s2 * 192'(n - 1);
    if ((d << 48) <= l) begin
      sat = 1'b1;
      u   = UNC_MAX;
      return;
    end
    for (int b = UNC_W - 1; b >= 0; b--) begin
      c = 192'(u | (24'd1 << b));
      if (c * c * d <= l) u[b] = 1'b1;
    end
  endfunction

  function automatic logic [SUM_W-1:0] sum_add(input logic [SUM_W-1:0] x,
                                              input logic [SUM_W:0] y, inout bit sat);
    logic [SUM_W+1:0] t;
    t = 50'(x) + 50'(y);
    if (t > 50'({SUM_W{1'b1}})) begin
      sat = 1'b1;
      return '1;
    end
    return t[SUM_W-1:0];
  endfunction

  function automatic logic [SQ_W-1:0] sq_add(input logic [SQ_W-1:0] x,
                                            input logic [SQ_W-1:0] y, inout bit sat);
    logic [SQ_W:0] t;
    t = 65'(x) + 65'(y);
    if (t[SQ_W]) begin
      sat = 1'b1;
      return '1;
    end
    return t[SQ_W-1:0];
  endfunction

  // applies one command to the predictor stores; returns 0 when no result
  function automatic bit apply_command(input vhs_item_t it, output vhs_result_t res);
    int unsigned       v;
    bit                sat, fb;
    logic [UNC_W-1:0]  unc;
    logic [PEND_W-1:0] t;
    logic [PEND_W:0]   p;
    res = '0;
    sat = 1'b0;
    fb  = 1'b0;
    unc = '0;
    v   = it.index;
    if (it.command == CMD_UNUSED || v >= VOXELS) return 1'b0;
    case (vhs_cmd_e'(it.command))
      CMD_RESET: begin
        sum_mem[v] = 48'(it.amount);
        if (track_en) sq_mem[v] = 64'(it.amount) * 64'(it.amount);
        pend_mem[v] = '0;
      end
      CMD_SET: sum_mem[v] = 48'(it.amount);
      CMD_ADD: sum_mem[v] = sum_add(sum_mem[v], 49'(it.amount), sat);
      CMD_ADD_TEMP: begin
        p = 33'(pend_mem[v]) + 33'(it.amount);
        if (p[PEND_W]) begin
          sat = 1'b1;
          pend_mem[v] = '1;
        end else begin
          pend_mem[v] = p[PEND_W-1:0];
        end
      end
      CMD_ADD_UPDATE: begin
        t = pend_mem[v];
        sum_mem[v] = sum_add(sum_mem[v], 49'(t), sat);
        if (track_en) sq_mem[v] = sq_add(sq_mem[v], 64'(t) * 64'(t), sat);
        pend_mem[v] = 32'(it.amount);
      end
      CMD_REPORT: begin
        // untracked report behaves as a plain read
        if (track_en) begin
          t = pend_mem[v];
          sum_mem[v]  = sum_add(sum_mem[v], 49'(t), sat);
          sq_mem[v]   = sq_add(sq_mem[v], 64'(t) * 64'(t), sat);
          pend_mem[v] = '0;
          rel_uncertainty(sum_mem[v], sq_mem[v], it.event_count, unc, fb, sat);
        end
      end
      default: ;
    endcase
    res.value_out   = sum_mem[v];
    res.squared_out = sq_mem[v];
    res.uncertainty = unc;
    res.fallback    = fb;
    res.saturated   = sat;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
  endtask

  // result checker: every strobe is one transaction, compared with the oldest
  // expectation
  always @(posedge clk_i) begin
    vhs_result_t want;
    if (rst_ni && result_strobe_o) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 64'(result_o.value_out), 64'd0);
      end else begin
        want = expected_q.pop_front();
        if (result_o.value_out !== want.value_out)
          report_mismatch("value_out", 64'(result_o.value_out), 64'(want.value_out));
        if (result_o.squared_out !== want.squared_out)
          report_mismatch("squared_out", result_o.squared_out, want.squared_out);
        if (result_o.uncertainty !== want.uncertainty)
          report_mismatch("uncertainty", 64'(result_o.uncertainty), 64'(want.uncertainty));
        if (result_o.fallback !== want.fallback)
          report_mismatch("fallback", 64'(result_o.fallback), 64'(want.fallback));
        if (result_o.saturated !== want.saturated)
          report_mismatch("saturated", 64'(result_o.saturated), 64'(want.saturated));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // sends one command transaction after a gap; start stays high on return so
  // a back-to-back item keeps it up
  task automatic send_item(input vhs_item_t it, input int unsigned gap);
    vhs_result_t res;
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    items_sent++;
    if (it.command == CMD_REPORT) reports_sent++;
    if (apply_command(it, res)) expected_q.push_back(res);
  endtask

  task automatic send_cmd(input vhs_cmd_e c, input int unsigned v,
                          input logic [AMT_W-1:0] amt, input logic [EVT_W-1:0] n);
    vhs_item_t it;
    it.command     = c;
    it.index       = IDX_W'(v);
    it.amount      = amt;
    it.event_count = n;
    send_item(it, $urandom_range(0, 9));
  endtask

  // lets every outstanding transaction finish, including silent ones
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_tracking(input bit en);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= en;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    track_en = en;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_untracked();
    write_tracking(1'b0);
    send_cmd(CMD_RESET, 0, 24'hFFFFFF, 0);
    send_cmd(CMD_ADD, 0, 24'hFFFFFF, 0);
    send_cmd(CMD_ADD_TEMP, 0, 24'h000001, 0);
    send_cmd(CMD_ADD_UPDATE, 0, 24'h123456, 0);
    send_cmd(CMD_REPORT, 0, 0, 32'hFFFFFFFF);  // acts as read
    send_cmd(CMD_SET, 4095, 24'hFFFFFF, 0);
    send_cmd(CMD_READ, 4095, 0, 0);
  endtask

  task automatic test_tracked_corners();
    write_tracking(1'b1);
    // fallback: sum zero, square zero, N of 0 and 1
    send_cmd(CMD_REPORT, 7, 0, 10);
    send_cmd(CMD_SET, 7, 24'd5, 0);
    send_cmd(CMD_REPORT, 7, 0, 10);
    send_cmd(CMD_RESET, 8, 24'd3, 0);
    send_cmd(CMD_REPORT, 8, 0, 0);
    send_cmd(CMD_REPORT, 8, 0, 1);
    // ordinary history: deposits in pending then folded
    send_cmd(CMD_ADD_TEMP, 8, 24'd4, 0);
    send_cmd(CMD_ADD_UPDATE, 8, 24'd6, 0);
    send_cmd(CMD_REPORT, 8, 0, 4);
    // negative radicand: large sum, small square, small N
    send_cmd(CMD_SET, 8, 24'hFFFFFF, 0);
    send_cmd(CMD_REPORT, 8, 0, 2);
    // uncertainty saturation: tiny sum, large square, huge N
    send_cmd(CMD_RESET, 9, 24'hFFFFFF, 0);
    send_cmd(CMD_SET, 9, 24'd1, 0);
    send_cmd(CMD_REPORT, 9, 0, 32'hFFFFFFFF);
    send_cmd(CMD_READ, 9, 0, 0);
    send_item('{command: CMD_UNUSED, index: 12'hFFF, amount: '1, event_count: '1}, 0);
  endtask

  // pending overflow and square overflow on one voxel
  task automatic test_overflow();
    for (int k = 0; k < 260; k++) send_cmd(CMD_ADD_TEMP, 100, 24'hFFFFFF, 0);
    send_cmd(CMD_ADD_UPDATE, 100, 24'hFFFFFF, 0);
    for (int k = 0; k < 260; k++) send_cmd(CMD_ADD_TEMP, 100, 24'hFFFFFF, 0);
    send_cmd(CMD_REPORT, 100, 0, 32'd3);
  endtask

  function automatic vhs_item_t random_item();
    vhs_item_t it;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3)       it.command = CMD_UNUSED;
    else if (r < 10) it.command = CMD_RESET;
    else if (r < 14) it.command = CMD_SET;
    else if (r < 24) it.command = CMD_ADD;
    else if (r < 50) it.command = CMD_ADD_TEMP;
    else if (r < 70) it.command = CMD_ADD_UPDATE;
    else if (r < 78) it.command = CMD_READ;
    else             it.command = CMD_REPORT;
    // mostly a few hot voxels so histories build up
    it.index = ($urandom_range(0, 9) < 8) ? IDX_W'($urandom_range(0, 7)) : IDX_W'($urandom);
    case ($urandom_range(0, 3))
      0:       it.amount = AMT_W'($urandom_range(0, 15));
      1:       it.amount = AMT_W'($urandom_range(0, 4095));
      2:       it.amount = 24'hFFFFFF - AMT_W'($urandom_range(0, 255));
      default: it.amount = AMT_W'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0:       it.event_count = EVT_W'($urandom_range(0, 2));
      1:       it.event_count = EVT_W'($urandom_range(3, 100));
      2:       it.event_count = EVT_W'($urandom_range(100, 100000));
      default: it.event_count = $urandom;
    endcase
    return it;
  endfunction

  task automatic test_random(input int unsigned count);
    for (int k = 0; k < count; k++) send_item(random_item(), $urandom_range(0, 9));
  endtask

  // bursts with no idle so the sequencer takes items back to back
  task automatic test_random_burst(input int unsigned count);
    for (int k = 0; k < count; k++) send_item(random_item(), 0);
  endtask

  initial begin
    errors = 0;
    results_seen = 0;
    items_sent = 0;
    reports_sent = 0;
    cycles = 0;
    track_en = 1'b0;
    for (int v = 0; v < VOXELS; v++) begin
      sum_mem[v]  = '0;
      sq_mem[v]   = '0;
      pend_mem[v] = '0;
    end
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_untracked();
    test_tracked_corners();
    test_overflow();
    test_random(250);
    write_tracking(1'b0);
    test_random(150);
    write_tracking(1'b1);
    test_random_burst(100);
    drain();  // sender holds off until every result is back
    test_random(200);
    write_tracking(1'b0);
    test_random_burst(50);
    write_tracking(1'b1);
    test_random(250);
    drain();

    $display("covered %0d command transactions, %0d reports, %0d results checked",
             items_sent, reports_sent, results_seen);
    $display("tracking toggled across phases, with fallback, clamp and overflow cases");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
